@@ rtl/pvp_pkg.sv @@
`timescale 1ns / 1ps

package pvp_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int SizeW    = 15;
  localparam int RegW     = 64;
  localparam int CfgIdxW  = 3;
  localparam int NumRows  = 3;
  localparam int ProdW    = 2 * DataW - FracBits;      // product after the fraction shift
  localparam int DotW     = ProdW + 2;                 // three products and a constant
  localparam int NumW     = DataW + SizeW;             // |c| * size
  localparam int DivW     = DataW + 1;                 // 2 * |w|
  localparam int HeadW    = NumW - DataW;              // dividend bits above the quotient window
  localparam int QuotW    = DataW + FracBits;          // quotient bits kept
  localparam int HugeExp  = 40 + FracBits;
  localparam int SumW     = HugeExp + 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegXRowFirst  = 3'd0,
    RegXRowSecond = 3'd1,
    RegYRowFirst  = 3'd2,
    RegYRowSecond = 3'd3,
    RegWRowFirst  = 3'd4,
    RegWRowSecond = 3'd5,
    RegWidth      = 3'd6,
    RegHeight     = 3'd7
  } cfg_idx_e;

  // partial remainder and a shared dividend/quotient shift register
  typedef struct packed {
    logic [DivW-1:0]  rem;
    logic [QuotW-1:0] qn;
  } div_lane_t;

  typedef struct packed {
    logic                    valid;
    div_lane_t               lx;
    div_lane_t               ly;
    logic [DivW-1:0]         dvs;
    logic                    ovx;
    logic                    ovy;
    logic                    negx;
    logic                    negy;
    logic                    wzero;
    logic                    sat;
    logic signed [DataW-1:0] w;
  } div_item_t;

  function automatic div_lane_t div_step(div_lane_t l, logic [DivW-1:0] d);
    logic [DivW:0] t;
    logic [DivW:0] diff;
    logic          ge;
    div_lane_t     r;
    t      = {l.rem, l.qn[QuotW-1]};
    diff   = t - {1'b0, d};
    ge     = (t >= {1'b0, d});
    r.rem  = ge ? diff[DivW-1:0] : t[DivW-1:0];
    r.qn   = {l.qn[QuotW-2:0], ge};
    return r;
  endfunction

endpackage

@@ rtl/pvp_div_step.sv @@
`timescale 1ns / 1ps

module pvp_div_step (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  pvp_pkg::div_item_t    item_i,
  output pvp_pkg::div_item_t    item_o
);

  logic               valid_q;
  pvp_pkg::div_item_t item_q, item_d;

  always_comb begin
    item_d    = item_i;
    item_d.lx = pvp_pkg::div_step(item_i.lx, item_i.dvs);
    item_d.ly = pvp_pkg::div_step(item_i.ly, item_i.dvs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  always_comb begin
    item_o       = item_q;
    item_o.valid = valid_q;
  end

endmodule

@@ rtl/perspective_viewport_projection.sv @@
`timescale 1ns / 1ps
// path: products, sums and clamp, magnitudes and scaling, divider setup, divider chain, output register
// throughput: one point per cycle while in_stall_o is low; two 48-step bit-serial dividers are fully pipelined
// an output register plus one skid entry decouple out_stall_i from in_stall_o
// reset clears all valid bits and loads the identity-like matrix and a 1920x1080 viewport
// in_stall_o is high only while the skid entry is occupied

module perspective_viewport_projection (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [pvp_pkg::DataW-1:0]     point_x_i,
  input  logic signed [pvp_pkg::DataW-1:0]     point_y_i,
  input  logic signed [pvp_pkg::DataW-1:0]     point_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pvp_pkg::DataW-1:0]     screen_x_o,
  output logic signed [pvp_pkg::DataW-1:0]     screen_y_o,
  output logic signed [pvp_pkg::DataW-1:0]     depth_w_o,
  output logic                                 w_is_zero_o,
  output logic                                 saturated_o,
  input  logic                                 cfg_we_i,
  input  logic [pvp_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [pvp_pkg::RegW-1:0]             cfg_wdata_i
);

  localparam int DataW = pvp_pkg::DataW;
  localparam int F     = pvp_pkg::FracBits;
  localparam int ProdW = pvp_pkg::ProdW;
  localparam int DotW  = pvp_pkg::DotW;
  localparam int NumW  = pvp_pkg::NumW;
  localparam int DivW  = pvp_pkg::DivW;
  localparam int HeadW = pvp_pkg::HeadW;
  localparam int QuotW = pvp_pkg::QuotW;
  localparam int SumW  = pvp_pkg::SumW;
  localparam int SizeW = pvp_pkg::SizeW;
  localparam int RegW  = pvp_pkg::RegW;
  localparam int NRows = pvp_pkg::NumRows;

  // ---------------- configuration ----------------
  logic [RegW-1:0]  mat_q [2*NRows];
  logic [SizeW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= RegW'(1) << (32 + F);
      mat_q[1] <= '0;
      mat_q[2] <= RegW'(1) << F;
      mat_q[3] <= '0;
      mat_q[4] <= '0;
      mat_q[5] <= RegW'(1) << F;
      width_q  <= SizeW'(1920);
      height_q <= SizeW'(1080);
    end else if (cfg_we_i) begin
      unique case (pvp_pkg::cfg_idx_e'(cfg_idx_i))
        pvp_pkg::RegXRowFirst:  mat_q[0] <= cfg_wdata_i;
        pvp_pkg::RegXRowSecond: mat_q[1] <= cfg_wdata_i;
        pvp_pkg::RegYRowFirst:  mat_q[2] <= cfg_wdata_i;
        pvp_pkg::RegYRowSecond: mat_q[3] <= cfg_wdata_i;
        pvp_pkg::RegWRowFirst:  mat_q[4] <= cfg_wdata_i;
        pvp_pkg::RegWRowSecond: mat_q[5] <= cfg_wdata_i;
        pvp_pkg::RegWidth:      width_q  <= cfg_wdata_i[SizeW-1:0];
        pvp_pkg::RegHeight:     height_q <= cfg_wdata_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic skid_v_q, out_v_q;
  logic en;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // ---------------- stage 1: nine products ----------------
  logic                    v1_q;
  logic signed [ProdW-1:0] prod_q [NRows][3];
  logic signed [ProdW-1:0] prod_d [NRows][3];
  logic signed [DataW-1:0] pt [3];

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  always_comb begin
    logic signed [2*DataW-1:0] p;
    logic [2*RegW-1:0]         cf;
    for (int r = 0; r < NRows; r++) begin
      for (int j = 0; j < 3; j++) begin
        cf = {mat_q[2*r], mat_q[2*r+1]} >> (DataW * (3 - j));
        p  = $signed(cf[DataW-1:0]) * pt[j];
        prod_d[r][j] = ProdW'(p >>> F);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
    end
  end

  // ---------------- stage 2: sums and clamp ----------------
  logic                    v2_q, sat2_q, sat2_d;
  logic signed [DataW-1:0] clip_q [NRows];
  logic signed [DataW-1:0] clip_d [NRows];

  always_comb begin
    logic signed [DotW-1:0] dot;
    logic [DataW-1:0]       c3;
    sat2_d = 1'b0;
    for (int r = 0; r < NRows; r++) begin
      c3  = mat_q[2*r+1][DataW-1:0];
      dot = DotW'(prod_q[r][0]) + DotW'(prod_q[r][1]) + DotW'(prod_q[r][2])
          + DotW'($signed(c3));
      if (&dot[DotW-1:DataW-1] || ~|dot[DotW-1:DataW-1]) begin
        clip_d[r] = dot[DataW-1:0];
      end else begin
        sat2_d    = 1'b1;
        clip_d[r] = dot[DotW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      clip_q <= clip_d;
      sat2_q <= sat2_d;
    end
  end

  // ---------------- stage 3: magnitudes and scaling ----------------
  logic                    v3_q, sat3_q, negx3_q, negy3_q, wz3_q;
  logic [NumW-1:0]         nx3_q, ny3_q;
  logic [DivW-1:0]         d3_q;
  logic signed [DataW-1:0] w3_q;
  logic [DataW-1:0]        acx, acy, aw;

  assign acx = clip_q[0][DataW-1] ? DataW'(-clip_q[0]) : clip_q[0];
  assign acy = clip_q[1][DataW-1] ? DataW'(-clip_q[1]) : clip_q[1];
  assign aw  = clip_q[2][DataW-1] ? DataW'(-clip_q[2]) : clip_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx3_q   <= NumW'(acx) * NumW'(width_q);
      ny3_q   <= NumW'(acy) * NumW'(height_q);
      d3_q    <= {aw, 1'b0};
      negx3_q <= clip_q[0][DataW-1] ^ clip_q[2][DataW-1];
      negy3_q <= clip_q[1][DataW-1] ^ clip_q[2][DataW-1];
      wz3_q   <= (clip_q[2] == '0);
      w3_q    <= clip_q[2];
      sat3_q  <= sat2_q;
    end
  end

  // ---------------- stage 4: divider setup ----------------
  logic               v4_q;
  pvp_pkg::div_item_t div4_q, div4_d;

  always_comb begin
    div4_d        = '0;
    div4_d.valid  = v3_q;
    div4_d.lx.rem = DivW'(nx3_q[NumW-1:DataW]);
    div4_d.lx.qn  = {nx3_q[DataW-1:0], {F{1'b0}}};
    div4_d.ly.rem = DivW'(ny3_q[NumW-1:DataW]);
    div4_d.ly.qn  = {ny3_q[DataW-1:0], {F{1'b0}}};
    div4_d.dvs    = d3_q;
    // quotient would reach 2^32 whole units
    div4_d.ovx    = (DivW'(nx3_q[NumW-1:NumW-HeadW]) >= d3_q);
    div4_d.ovy    = (DivW'(ny3_q[NumW-1:NumW-HeadW]) >= d3_q);
    div4_d.negx   = negx3_q;
    div4_d.negy   = negy3_q;
    div4_d.wzero  = wz3_q;
    div4_d.sat    = sat3_q;
    div4_d.w      = w3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div4_q <= div4_d;
    end
  end

  // ---------------- divider chain ----------------
  pvp_pkg::div_item_t div_chain [QuotW+1];

  always_comb begin
    div_chain[0]       = div4_q;
    div_chain[0].valid = v4_q;
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_div
    pvp_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .item_i (div_chain[k]),
      .item_o (div_chain[k+1])
    );
  end

  // ---------------- final: offset, clamp ----------------
  pvp_pkg::div_item_t      fin;
  logic signed [DataW-1:0] sx_d, sy_d;
  logic                    sat_d;

  assign fin = div_chain[QuotW];

  always_comb begin
    logic [SumW-1:0]        magx, magy;
    logic signed [SumW-1:0] qx, qy, sx, sy, half;
    half  = SumW'(1) << (F - 1);
    magx  = fin.ovx ? (SumW'(1) << pvp_pkg::HugeExp) : SumW'(fin.lx.qn);
    magy  = fin.ovy ? (SumW'(1) << pvp_pkg::HugeExp) : SumW'(fin.ly.qn);
    qx    = fin.negx ? -$signed(magx) : $signed(magx);
    qy    = fin.negy ? -$signed(magy) : $signed(magy);
    sx    = $signed(SumW'(width_q) << (F - 1)) + qx + half;
    sy    = $signed(SumW'(height_q) << (F - 1)) - qy - half;
    sat_d = fin.sat;
    sx_d  = '0;
    sy_d  = '0;
    if (!fin.wzero) begin
      if (&sx[SumW-1:DataW-1] || ~|sx[SumW-1:DataW-1]) begin
        sx_d = sx[DataW-1:0];
      end else begin
        sat_d = 1'b1;
        sx_d  = sx[SumW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
      end
      if (&sy[SumW-1:DataW-1] || ~|sy[SumW-1:DataW-1]) begin
        sy_d = sy[DataW-1:0];
      end else begin
        sat_d = 1'b1;
        sy_d  = sy[SumW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
      end
    end
  end

  // ---------------- output register and skid entry ----------------
  logic                    inc;
  logic                    out_take;
  logic signed [DataW-1:0] osx_q, osy_q, ow_q, ksx_q, ksy_q, kw_q;
  logic                    owz_q, osat_q, kwz_q, ksat_q;

  assign inc      = fin.valid && en;
  assign out_take = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_take) begin
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || !out_stall_i) begin
      out_v_q <= inc;
    end else if (inc) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_take) begin
        osx_q  <= ksx_q;
        osy_q  <= ksy_q;
        ow_q   <= kw_q;
        owz_q  <= kwz_q;
        osat_q <= ksat_q;
      end
    end else if (!out_v_q || !out_stall_i) begin
      osx_q  <= sx_d;
      osy_q  <= sy_d;
      ow_q   <= fin.w;
      owz_q  <= fin.wzero;
      osat_q <= sat_d;
    end else begin
      ksx_q  <= sx_d;
      ksy_q  <= sy_d;
      kw_q   <= fin.w;
      kwz_q  <= fin.wzero;
      ksat_q <= sat_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign screen_x_o  = osx_q;
  assign screen_y_o  = osy_q;
  assign depth_w_o   = ow_q;
  assign w_is_zero_o = owz_q;
  assign saturated_o = osat_q;

  // ---------------- assertions ----------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry holds data while output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i && fin.valid))
    else $error("skid entry filled without a stalled output");

  a_zero_w_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && w_is_zero_o) |-> (screen_x_o == '0 && screen_y_o == '0 &&
                                      depth_w_o == '0))
    else $error("zero w result carries nonzero values");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !out_stall_i) |=> (!skid_v_q && out_v_q))
    else $error("skid entry did not move to the output register");

endmodule

@@ dv/tb_perspective_viewport_projection.sv @@
`timescale 1ns / 1ps

module tb_perspective_viewport_projection;

  localparam int DataW    = pvp_pkg::DataW;
  localparam int CfgIdxW  = pvp_pkg::CfgIdxW;
  localparam int RegW     = pvp_pkg::RegW;
  localparam int SizeW    = pvp_pkg::SizeW;
  localparam int FracBits = pvp_pkg::FracBits;
  localparam int HugeExp  = pvp_pkg::HugeExp;

  typedef struct {
    logic signed [DataW-1:0] px;
    logic signed [DataW-1:0] py;
    logic signed [DataW-1:0] pz;
  } point_t;

  typedef struct {
    logic signed [DataW-1:0] sx;
    logic signed [DataW-1:0] sy;
    logic signed [DataW-1:0] w;
    logic                    wz;
    logic                    sat;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DataW-1:0] point_x_i = '0;
  logic signed [DataW-1:0] point_y_i = '0;
  logic signed [DataW-1:0] point_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DataW-1:0] screen_x_o, screen_y_o, depth_w_o;
  logic w_is_zero_o, saturated_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [RegW-1:0] cfg_wdata_i = '0;

  perspective_viewport_projection DUT (.*);

  always #10 clk_i = ~clk_i;

  // mirror of the block's configuration
  logic [RegW-1:0] matrix_q [6];
  logic [SizeW-1:0] view_w, view_h;

  point_t point_q [$];
  pixel_t pixel_q [$];
  int errors = 0;
  int tx_gap = 0, rx_gap = 0;
  bit tx_burst = 1'b0, rx_burst = 1'b0;
  bit hold_req = 1'b0;
  logic rx_hold = 1'b0;

  function automatic longint clamp32(longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint row_dot(logic [RegW-1:0] a, logic [RegW-1:0] b, point_t p);
    longint acc;
    acc = (longint'(signed'(a[63:32])) * longint'(p.px)) >>> FracBits;
    acc += (longint'(signed'(a[31:0])) * longint'(p.py)) >>> FracBits;
    acc += (longint'(signed'(b[63:32])) * longint'(p.pz)) >>> FracBits;
    acc += longint'(signed'(b[31:0]));
    return acc;
  endfunction

  // (c * size) / (2w), truncated toward zero, huge quotients pinned
  function automatic longint view_div(longint c, longint w, longint unsigned size);
    longint unsigned ac, aw, d, n, q0, r, mag;
    ac = c < 0 ? longint'(-c) : c;
    aw = w < 0 ? longint'(-w) : w;
    d = aw * 2;
    n = ac * size;
    q0 = n / d;
    r = n % d;
    if (q0 >= (64'd1 << 32)) mag = 64'd1 << HugeExp;
    else mag = (q0 << FracBits) + ((r << FracBits) / d);
    return ((c < 0) != (w < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic pixel_t project_point(point_t p);
    pixel_t o;
    bit f;
    longint cx, cy, w, sx, sy, half;
    f = 1'b0;
    sx = 0;
    sy = 0;
    half = 64'sd1 << (FracBits - 1);
    cx = clamp32(row_dot(matrix_q[0], matrix_q[1], p), f);
    cy = clamp32(row_dot(matrix_q[2], matrix_q[3], p), f);
    w = clamp32(row_dot(matrix_q[4], matrix_q[5], p), f);
    if (w != 0) begin
      sx = (longint'(view_w) << (FracBits - 1)) + view_div(cx, w, 64'(view_w)) + half;
      sy = (longint'(view_h) << (FracBits - 1)) - view_div(cy, w, 64'(view_h)) - half;
      sx = clamp32(sx, f);
      sy = clamp32(sy, f);
    end
    o.sx = sx[31:0];
    o.sy = sy[31:0];
    o.w = w[31:0];
    o.wz = (w == 0);
    o.sat = f;
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pixel_q = {pixel_q, project_point(point_q[0])};
        void'(point_q.pop_front());
      end
      if (in_valid_i && in_stall_o) begin
        // stalled transfer holds its payload
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (point_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        point_x_i <= point_q[0].px;
        point_y_i <= point_q[0].py;
        point_z_i <= point_q[0].pz;
        tx_gap = tx_burst ? 0 : pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pixel_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected result sx=%h sy=%h", $time, screen_x_o, screen_y_o);
          errors++;
        end else begin
          e = pixel_q.pop_front();
          if (screen_x_o !== e.sx) begin
            $display("%0t: screen_x exp %h got %h", $time, e.sx, screen_x_o);
            errors++;
          end
          if (screen_y_o !== e.sy) begin
            $display("%0t: screen_y exp %h got %h", $time, e.sy, screen_y_o);
            errors++;
          end
          if (depth_w_o !== e.w) begin
            $display("%0t: depth_w exp %h got %h", $time, e.w, depth_w_o);
            errors++;
          end
          if (w_is_zero_o !== e.wz) begin
            $display("%0t: w_is_zero exp %b got %b", $time, e.wz, w_is_zero_o);
            errors++;
          end
          if (saturated_o !== e.sat) begin
            $display("%0t: saturated exp %b got %b", $time, e.sat, saturated_o);
            errors++;
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_stall_i <= 1'b1;
      end else begin
        rx_gap = rx_burst ? 0 : pick_gap();
        out_stall_i <= rx_hold;
      end
    end
  end

  // long receiver hold-off so the pipeline fills and backs up
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [DataW-1:0] rand_q();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 * 65536 * 8)) - 65536 * 8);
      2: return 32'($signed($urandom_range(2 * 65536 * 1024)) - 65536 * 1024);
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      4: return 32'($signed($urandom_range(64)) - 32);
      default: return '0;
    endcase
  endfunction

  task automatic add_point(logic [DataW-1:0] x, logic [DataW-1:0] y, logic [DataW-1:0] z);
    point_t p;
    p.px = x;
    p.py = y;
    p.pz = z;
    point_q = {point_q, p};
  endtask

  task automatic write_reg(pvp_pkg::cfg_idx_e idx, logic [RegW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == pvp_pkg::RegWidth) view_w = val[SizeW-1:0];
    else if (idx == pvp_pkg::RegHeight) view_h = val[SizeW-1:0];
    else matrix_q[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_view(logic [RegW-1:0] m [6], logic [RegW-1:0] wv, logic [RegW-1:0] hv);
    write_reg(pvp_pkg::RegXRowFirst, m[0]);
    write_reg(pvp_pkg::RegXRowSecond, m[1]);
    write_reg(pvp_pkg::RegYRowFirst, m[2]);
    write_reg(pvp_pkg::RegYRowSecond, m[3]);
    write_reg(pvp_pkg::RegWRowFirst, m[4]);
    write_reg(pvp_pkg::RegWRowSecond, m[5]);
    write_reg(pvp_pkg::RegWidth, wv);
    write_reg(pvp_pkg::RegHeight, hv);
  endtask

  task automatic drain();
    wait (point_q.size() == 0 && pixel_q.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_points(int n);
    repeat (n) add_point(rand_q(), rand_q(), rand_q());
  endtask

  initial begin
    logic [RegW-1:0] m [6];
    matrix_q[0] = 64'd1 << 48;
    matrix_q[1] = '0;
    matrix_q[2] = 64'd1 << 16;
    matrix_q[3] = '0;
    matrix_q[4] = '0;
    matrix_q[5] = 64'd1 << 16;
    view_w = 15'd1920;
    view_h = 15'd1080;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset matrix: directed extremes with no idling, then random
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    add_point('0, '0, '0);
    add_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_point(32'h80000000, 32'h80000000, 32'h80000000);
    add_point(32'hffffffff, 32'h00000001, 32'h00010000);
    add_point(32'h00008000, 32'hffff8000, '0);
    wait (point_q.size() == 0);
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    random_points(300);
    drain();

    // perspective divide by z: zero w, tiny w, saturation; receiver hold-off
    m[0] = {32'h00010000, 32'h0};
    m[1] = {32'h0, 32'h0};
    m[2] = {32'h0, 32'h00010000};
    m[3] = {32'h0, 32'h0};
    m[4] = {32'h0, 32'h0};
    m[5] = {32'h00010000, 32'h0};
    write_view(m, 64'd16384, 64'd1);
    add_point(32'h00010000, 32'h00010000, '0);
    add_point(32'h80000000, 32'h7fffffff, '0);
    add_point(32'h7fffffff, 32'h80000000, 32'h00000001);
    add_point(32'h80000000, 32'h80000000, 32'hffffffff);
    add_point(32'h00050000, 32'hfffb0000, 32'h000a0000);
    add_point(32'h00000001, 32'h00000001, 32'h7fffffff);
    add_point(32'h00010000, 32'h00010000, 32'h80000000);
    tx_burst = 1'b1;
    random_points(450);
    hold_req = 1'b1;
    wait (rx_hold === 1'b1);
    wait (rx_hold === 1'b0);
    tx_burst = 1'b0;
    drain();

    // random matrices, size extremes including ignored upper data bits
    for (int ph = 0; ph < 3; ph++) begin
      foreach (m[i]) m[i] = {rand_q(), rand_q()};
      case (ph)
        0: write_view(m, 64'd1, 64'd16384);
        1: write_view(m, {$urandom(), $urandom()} & ~64'h7fff, 64'h7fff);
        default: write_view(m, 64'($urandom_range(16384, 1)), 64'($urandom_range(16384, 1)));
      endcase
      random_points(350);
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pvp_pkg.sv
rtl/pvp_div_step.sv
rtl/perspective_viewport_projection.sv
dv/tb_perspective_viewport_projection.sv
